@@ rtl/smir_pkg.sv @@
// smir_pkg: types, sizes and the range ordering for sort_and_merge_index_ranges
// used by smir_cell, smir_merge and the top level; depends on nothing

package smir_pkg;

    localparam int MAX_RANGES = 64;
    localparam int INDEX_BITS = 32;
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    typedef struct packed {
        logic [INDEX_BITS-1:0] range_first;
        logic [INDEX_BITS-1:0] range_last;
        logic                  end_of_set;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] merged_first;
        logic [INDEX_BITS-1:0] merged_last;
        logic                  last_of_run;
        logic                  overflow;
    } t_out_item;

    typedef struct packed {
        logic                  vld;
        logic [INDEX_BITS-1:0] first;
        logic [INDEX_BITS-1:0] last;
    } t_range;

    typedef struct packed {
        logic shift;
    } t_cell_ctl;

    function automatic logic range_less(input t_range a, input t_range b);
        logic res;
        if (a.first == b.first) begin
            res = (a.last < b.last);
        end else begin
            res = (a.first < b.first);
        end
        return res;
    endfunction

endpackage

@@ rtl/smir_cell.sv @@
// smir_cell: one cell of the insertion sort chain, keeps the smaller range
// and passes the larger one on; shifts left while draining; uses smir_pkg

module smir_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smir_pkg::t_cell_ctl i_ctl,
    input  smir_pkg::t_range    i_pass,
    input  smir_pkg::t_range    i_next,
    output smir_pkg::t_range    o_held,
    output smir_pkg::t_range    o_pass
);

    smir_pkg::t_range r_held;
    smir_pkg::t_range r_pass;
    smir_pkg::t_range n_held;
    smir_pkg::t_range n_pass;

    always_comb begin
        n_held     = r_held;
        n_pass     = i_pass;
        n_pass.vld = 1'b0;
        if (i_ctl.shift) begin
            n_held = i_next;
        end else if (i_pass.vld) begin
            if (!r_held.vld) begin
                n_held = i_pass;
            end else if (smir_pkg::range_less(i_pass, r_held)) begin
                n_held = i_pass;
                n_pass = r_held;
            end else begin
                n_pass = i_pass;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.vld <= 1'b0;
            r_pass.vld <= 1'b0;
        end else begin
            r_held <= n_held;
            r_pass <= n_pass;
        end
    end

    assign o_held = r_held;
    assign o_pass = r_pass;

endmodule

@@ rtl/smir_merge.sv @@
// smir_merge: folds the sorted ranges from the head of the chain into
// merged ranges and holds the result register; uses smir_pkg

module smir_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_drain,
    input  smir_pkg::t_range    i_head,
    input  logic                i_dropped,
    input  logic                i_out_ready,
    output logic                o_take,
    output logic                o_done,
    output logic                o_out_valid,
    output smir_pkg::t_out_item o_out_data
);

    localparam int IW = smir_pkg::INDEX_BITS;

    logic                r_run_vld;
    logic [IW-1:0]       r_run_f;
    logic [IW-1:0]       r_run_l;
    logic                r_out_vld;
    smir_pkg::t_out_item r_out;

    logic                n_run_vld;
    logic [IW-1:0]       n_run_f;
    logic [IW-1:0]       n_run_l;
    logic                n_out_vld;
    smir_pkg::t_out_item n_out;

    logic                out_free;
    logic                touch;
    logic [IW:0]         run_l_inc;

    assign out_free  = !r_out_vld || i_out_ready;
    assign run_l_inc = {1'b0, r_run_l} + {{IW{1'b0}}, 1'b1};
    assign touch     = (i_head.first <= r_run_l) || ({1'b0, i_head.first} == run_l_inc);

    always_comb begin
        n_run_vld = r_run_vld;
        n_run_f   = r_run_f;
        n_run_l   = r_run_l;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        o_take    = 1'b0;
        o_done    = 1'b0;
        if (i_drain) begin
            if (i_head.vld) begin
                if (!r_run_vld) begin
                    n_run_vld = 1'b1;
                    n_run_f   = i_head.first;
                    n_run_l   = i_head.last;
                    o_take    = 1'b1;
                end else if (touch) begin
                    if (i_head.last > r_run_l) begin
                        n_run_l = i_head.last;
                    end
                    o_take = 1'b1;
                end else if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out.merged_first = r_run_f;
                    n_out.merged_last  = r_run_l;
                    n_out.last_of_run  = 1'b0;
                    n_out.overflow     = i_dropped;
                    n_run_f            = i_head.first;
                    n_run_l            = i_head.last;
                    o_take             = 1'b1;
                end
            end else if (r_run_vld && out_free) begin
                n_out_vld          = 1'b1;
                n_out.merged_first = r_run_f;
                n_out.merged_last  = r_run_l;
                n_out.last_of_run  = 1'b1;
                n_out.overflow     = i_dropped;
                n_run_vld          = 1'b0;
                o_done             = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_run_vld <= n_run_vld;
            r_out_vld <= n_out_vld;
        end
        r_run_f <= n_run_f;
        r_run_l <= n_run_l;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/sort_and_merge_index_ranges.sv @@
// sort_and_merge_index_ranges: top level, input stage, chain of sort cells
// and merge stage; uses smir_pkg, smir_cell and smir_merge
//
//   channel  handshake                  payload
//   in       i_in_valid / o_in_ready    i_in_data  (smir_pkg::t_in_item)
//   out      o_out_valid / i_out_ready  o_out_data (smir_pkg::t_out_item)
//
// loading takes one transfer per cycle; each range ripples through the cell chain
// after the closing transfer the chain settles until no range is left in flight
// draining moves one stored range per cycle from the chain head into the merge stage
// unless a merged range waits on a stalled output; no input while settling or draining
// synchronous active-low reset empties the chain and the counters

module sort_and_merge_index_ranges (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  smir_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output smir_pkg::t_out_item o_out_data
);

    localparam int N  = smir_pkg::MAX_RANGES;
    localparam int CW = smir_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    logic              r_dropped;
    smir_pkg::t_range  r_in;

    smir_pkg::t_range  w_pass [0:N];
    smir_pkg::t_range  w_held [0:N];
    logic [N-1:0]      w_pass_vld;
    smir_pkg::t_cell_ctl w_ctl;

    logic              accept;
    logic              has_room;
    logic              settled;
    logic              take;
    logic              done;

    assign o_in_ready = (r_state == ST_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign has_room   = (r_cnt < CW'(N));
    assign settled    = !r_in.vld && !(|w_pass_vld);
    assign w_ctl.shift = take;

    assign w_pass[0] = r_in;
    always_comb begin
        w_held[N]       = r_in;
        w_held[N].vld   = 1'b0;
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            smir_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_pass  (w_pass[g]),
                .i_next  (w_held[g+1]),
                .o_held  (w_held[g]),
                .o_pass  (w_pass[g+1])
            );
            assign w_pass_vld[g] = w_pass[g+1].vld;
        end
    endgenerate

    smir_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_drain     (r_state == ST_DRAIN),
        .i_head      (w_held[0]),
        .i_dropped   (r_dropped),
        .i_out_ready (i_out_ready),
        .o_take      (take),
        .o_done      (done),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_cnt     <= '0;
            r_dropped <= 1'b0;
            r_in.vld  <= 1'b0;
        end else begin
            r_in.vld <= accept && has_room;
            case (r_state)
                ST_LOAD: begin
                    if (accept) begin
                        if (has_room) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                        if (i_in_data.end_of_set) begin
                            r_state <= ST_SETTLE;
                        end
                    end
                end
                ST_SETTLE: begin
                    if (settled) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (done) begin
                        r_state   <= ST_LOAD;
                        r_cnt     <= '0;
                        r_dropped <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
        if (i_in_data.range_first > i_in_data.range_last) begin
            r_in.first <= i_in_data.range_last;
            r_in.last  <= i_in_data.range_first;
        end else begin
            r_in.first <= i_in_data.range_first;
            r_in.last  <= i_in_data.range_last;
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking testbench for sort_and_merge_index_ranges; a directed table and
// random range sets are checked against an in-bench sort-and-merge predictor
// depends on smir_pkg and the sort_and_merge_index_ranges RTL

module tb_top;

    localparam int MAX_R       = smir_pkg::MAX_RANGES;
    localparam int IW          = smir_pkg::INDEX_BITS;
    localparam int TOTAL_ITEMS = 430;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_WAIT = 2 * MAX_R + 16;

    typedef struct {
        smir_pkg::t_in_item  stim;
        bit                  typed;
        smir_pkg::t_out_item want;
    } t_row;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    smir_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    smir_pkg::t_out_item out_data;

    // predictor state
    logic [IW-1:0] held_first [MAX_R];
    logic [IW-1:0] held_last  [MAX_R];
    int unsigned   held_count   = 0;
    bit            held_dropped = 1'b0;

    smir_pkg::t_out_item expected_merged [$];
    smir_pkg::t_out_item oldest_merged;
    t_row                directed_rows [$];

    int unsigned send_idle_pct   = 0;
    int unsigned recv_stall_pct  = 0;
    int unsigned ranges_sent     = 0;
    int unsigned sets_closed     = 0;
    int unsigned overflow_sets   = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches      = 0;
    int unsigned idle_cycles     = 0;

    sort_and_merge_index_ranges i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_mismatch(input string what, input logic [IW-1:0] got,
                                 input logic [IW-1:0] want);
        if (mismatches < 40) begin
            $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic predict_merged_ranges(input smir_pkg::t_in_item it);
        logic [IW-1:0]       lo, hi, key_lo, key_hi, run_lo, run_hi;
        int                  i, j;
        smir_pkg::t_out_item res;
        lo = (it.range_first > it.range_last) ? it.range_last : it.range_first;
        hi = (it.range_first > it.range_last) ? it.range_first : it.range_last;
        if (held_count < MAX_R) begin
            held_first[held_count] = lo;
            held_last[held_count]  = hi;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!it.end_of_set) return;
        sets_closed++;
        if (held_dropped) overflow_sets++;
        // order by first, then by last
        for (i = 1; i < held_count; i++) begin
            key_lo = held_first[i];
            key_hi = held_last[i];
            j = i;
            while (j > 0 && (held_first[j-1] > key_lo ||
                   (held_first[j-1] == key_lo && held_last[j-1] > key_hi))) begin
                held_first[j] = held_first[j-1];
                held_last[j]  = held_last[j-1];
                j--;
            end
            held_first[j] = key_lo;
            held_last[j]  = key_hi;
        end
        run_lo = held_first[0];
        run_hi = held_last[0];
        for (i = 1; i < held_count; i++) begin
            // touch test one bit wider, no wrap at the top index
            if (held_first[i] <= run_hi || {1'b0, held_first[i]} == {1'b0, run_hi} + 1'b1) begin
                if (held_last[i] > run_hi) run_hi = held_last[i];
            end else begin
                res = '{merged_first: run_lo, merged_last: run_hi, last_of_run: 1'b0,
                        overflow: held_dropped};
                expected_merged = {expected_merged, res};
                run_lo = held_first[i];
                run_hi = held_last[i];
            end
        end
        res = '{merged_first: run_lo, merged_last: run_hi, last_of_run: 1'b1,
                overflow: held_dropped};
        expected_merged = {expected_merged, res};
        held_count   = 0;
        held_dropped = 1'b0;
    endtask

    task automatic set_phase();
        case ((ranges_sent * 4) / TOTAL_ITEMS)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 60;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 60;
            end
            default: begin
                send_idle_pct  = 24;
                recv_stall_pct = 24;
            end
        endcase
    endtask

    // one input transfer; the predictor runs at the accepting edge
    task automatic send_range(input smir_pkg::t_in_item it);
        set_phase();
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ranges_sent++;
        predict_merged_ranges(it);
    endtask

    task automatic add_row(input logic [IW-1:0] first, input logic [IW-1:0] last,
                           input bit eos, input bit typed,
                           input logic [IW-1:0] want_first, input logic [IW-1:0] want_last);
        t_row r;
        r.stim  = '{range_first: first, range_last: last, end_of_set: eos};
        r.typed = typed;
        r.want  = '{merged_first: want_first, merged_last: want_last, last_of_run: 1'b1,
                    overflow: 1'b0};
        directed_rows = {directed_rows, r};
    endtask

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (expected_merged.size() == 0) begin
                note_mismatch("merged range with none expected", out_data.merged_first, '0);
            end else begin
                oldest_merged = expected_merged.pop_front();
                if (out_data.merged_first !== oldest_merged.merged_first)
                    note_mismatch("merged_first", out_data.merged_first,
                                  oldest_merged.merged_first);
                if (out_data.merged_last !== oldest_merged.merged_last)
                    note_mismatch("merged_last", out_data.merged_last,
                                  oldest_merged.merged_last);
                if (out_data.last_of_run !== oldest_merged.last_of_run)
                    note_mismatch("last_of_run", IW'(out_data.last_of_run),
                                  IW'(oldest_merged.last_of_run));
                if (out_data.overflow !== oldest_merged.overflow)
                    note_mismatch("overflow", IW'(out_data.overflow),
                                  IW'(oldest_merged.overflow));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("sort_and_merge_index_ranges verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [IW-1:0]      top_idx, base, a, b, t;
        int unsigned        set_size, mode, k, random_sets;
        smir_pkg::t_in_item it;
        top_idx     = '1;
        random_sets = 0;

        // single ranges with results read off directly
        add_row(0, 0, 1, 1, 0, 0);
        add_row(top_idx, top_idx, 1, 1, top_idx, top_idx);
        add_row(0, top_idx, 1, 1, 0, top_idx);
        add_row(10, 5, 1, 1, 5, 10);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 1, 1, 32'h5555_5555, 32'hAAAA_AAAA);
        // touching, gap of one, top of the index space
        add_row(5, 9, 0, 0, 0, 0);
        add_row(10, 12, 1, 0, 0, 0);
        add_row(0, 3, 0, 0, 0, 0);
        add_row(5, 7, 1, 0, 0, 0);
        add_row(top_idx - 1, top_idx, 0, 0, 0, 0);
        add_row(top_idx, top_idx, 1, 0, 0, 0);
        add_row(0, top_idx - 1, 0, 0, 0, 0);
        add_row(top_idx, top_idx, 1, 0, 0, 0);
        // unsorted, equal firsts, inverted bounds
        add_row(20, 30, 0, 0, 0, 0);
        add_row(1, 2, 0, 0, 0, 0);
        add_row(20, 25, 0, 0, 0, 0);
        add_row(1, 5, 0, 0, 0, 0);
        add_row(3, 3, 0, 0, 0, 0);
        add_row(40, 35, 1, 0, 0, 0);
        // containment and a late touch
        add_row(100, 200, 0, 0, 0, 0);
        add_row(150, 160, 0, 0, 0, 0);
        add_row(300, 400, 0, 0, 0, 0);
        add_row(201, 250, 1, 0, 0, 0);
        add_row(7, 7, 0, 0, 0, 0);
        add_row(7, 7, 1, 0, 0, 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_range(directed_rows[r].stim);
            if (directed_rows[r].typed) begin
                void'(expected_merged.pop_back());
                expected_merged = {expected_merged, directed_rows[r].want};
            end
        end

        // random sets: full store, one dropped on the closing transfer, then mixed sizes
        while (ranges_sent < TOTAL_ITEMS) begin
            if (random_sets == 0) set_size = MAX_R;
            else if (random_sets == 1) set_size = MAX_R + 1;
            else if ($urandom_range(99) < 4) set_size = $urandom_range(MAX_R + 6, MAX_R - 4);
            else set_size = $urandom_range(10, 1);
            mode = $urandom_range(3);
            base = $urandom;
            for (k = 0; k < set_size; k++) begin
                case (mode)
                    0: begin
                        a = base + IW'($urandom_range(60));
                        b = a + IW'($urandom_range(8));
                        if ($urandom_range(99) < 15) begin
                            t = a;
                            a = b;
                            b = t;
                        end
                    end
                    1: begin
                        a = $urandom;
                        b = $urandom;
                    end
                    2: begin
                        a = top_idx - IW'($urandom_range(40));
                        b = top_idx - IW'($urandom_range(40));
                    end
                    default: begin
                        a = $urandom_range(40);
                        b = $urandom_range(40);
                    end
                endcase
                it = '{range_first: a, range_last: b, end_of_set: (k == set_size - 1)};
                send_range(it);
            end
            random_sets++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_merged.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("ran %0d ranges in %0d sets, %0d merged ranges checked",
                 ranges_sent, sets_closed, results_checked);
        $display("%0d sets over capacity; idle phases: none, sender, receiver, both",
                 overflow_sets);
        if (mismatches == 0) begin
            $display("sort_and_merge_index_ranges verification clean");
        end else begin
            $display("sort_and_merge_index_ranges verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/smir_pkg.sv
rtl/smir_cell.sv
rtl/smir_merge.sv
rtl/sort_and_merge_index_ranges.sv
dv/tb_top.sv
